[src/kfst_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Keyed flow state table package
// Shared constants, operation and status codes for the flow state table.
// ----------------------------------------------------------------------------
package kfst_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 64;
  localparam int KEY_BYTES     = 8;
  localparam int KEY_W         = 8 * KEY_BYTES;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Field widths fixed by the interface.
  localparam int OP_W    = 2;
  localparam int FKEY_W  = 64;
  localparam int LEN_W   = 4;
  localparam int STATE_W = 32;
  localparam int TAB_W   = 8;
  localparam int STAT_W  = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_SET    = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
  localparam logic [STAT_W-1:0] ST_KEY_MISSING  = 2'd1;
  localparam logic [STAT_W-1:0] ST_LEN_MISMATCH = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL         = 2'd3;

endpackage : kfst_pkg
`default_nettype wire

[src/keyed_flow_state_table_top.sv]
`default_nettype none
// A lookup, set or delete that passes its checks gives its result strobe after the scan,
// which reads one entry per cycle, and the drain and decide states; busy drops in the
// strobe cycle, so the block takes no new item until the current one has its result.
// An item rejected by its key checks, or with an unused operation, gives its strobe
// in the next cycle and busy stays low. The receiver cannot stall.
// Reset clears all valid bits together and the config register to 0; no clearing pass.
// ----------------------------------------------------------------------------
// Keyed flow state table
// Exact-match table of flow keys to 32-bit states with lookup, masked set and
// delete. Keys and states live in one synchronous memory scanned per item.
// ----------------------------------------------------------------------------
module keyed_flow_state_table_top (
  input  wire                              clk,
  input  wire                              rst_n,
  // Configuration port
  input  wire                              cfg_wr_en,
  input  wire  [kfst_pkg::LEN_W-1:0]       cfg_wr_data,
  // Command channel
  input  wire                              start,
  output logic                             busy,
  input  wire  [kfst_pkg::OP_W-1:0]        in_operation,
  input  wire  [kfst_pkg::FKEY_W-1:0]      in_flow_key,
  input  wire                              in_key_complete,
  input  wire                              in_from_packet,
  input  wire  [kfst_pkg::LEN_W-1:0]       in_message_key_bytes,
  input  wire  [kfst_pkg::STATE_W-1:0]     in_new_state,
  input  wire  [kfst_pkg::STATE_W-1:0]     in_state_mask,
  input  wire  [kfst_pkg::TAB_W-1:0]       in_table_number,
  // Result channel
  output logic                             out_valid,
  output logic [kfst_pkg::STATE_W-1:0]     out_result_state,
  output logic                             out_hit,
  output logic                             out_notify,
  output logic [kfst_pkg::TAB_W-1:0]       out_notify_table,
  output logic [kfst_pkg::STAT_W-1:0]      out_status
);
  import kfst_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam int               MEM_W    = KEY_W + STATE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_t;

  state_t state_r;

  // Configuration and latched command.
  logic [LEN_W-1:0]   upd_key_bytes_r;
  logic [OP_W-1:0]    op_r;
  logic [KEY_W-1:0]   key_r;
  logic [STATE_W-1:0] nstate_r;
  logic [STATE_W-1:0] mask_r;
  logic [TAB_W-1:0]   tab_r;

  // Scan and match tracking.
  logic [IDX_W-1:0]   scan_idx_r;
  logic               cmp_en_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic               found_r;
  logic [IDX_W-1:0]   match_idx_r;
  logic [STATE_W-1:0] match_state_r;
  logic               free_found_r;
  logic [IDX_W-1:0]   free_idx_r;

  // Valid bits and the key/state memory.
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [MEM_W-1:0]         mem [TABLE_ENTRIES];
  logic [MEM_W-1:0]         rd_data_r;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  logic [MEM_W-1:0]         mem_wdata;

  // Combinational decode.
  logic               accept;
  logic               acc_reject;
  logic [STAT_W-1:0]  acc_status;
  logic [KEY_W-1:0]   rd_key;
  logic [STATE_W-1:0] rd_state;
  logic               cmp_match;
  logic               cmp_free;
  logic [STATE_W-1:0] merged;
  logic [STATE_W-1:0] ins_state;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Checks made at the start transfer; an unused operation is rejected with status OK.
  always_comb begin
    acc_reject = 1'b0;
    acc_status = ST_OK;
    unique case (in_operation)
      OP_LOOKUP: begin
        if (!in_key_complete) begin
          acc_reject = 1'b1;
          acc_status = ST_KEY_MISSING;
        end
      end
      OP_SET: begin
        if (in_from_packet && !in_key_complete) begin
          acc_reject = 1'b1;
          acc_status = ST_KEY_MISSING;
        end else if (!in_from_packet && (in_message_key_bytes != upd_key_bytes_r)) begin
          acc_reject = 1'b1;
          acc_status = ST_LEN_MISMATCH;
        end
      end
      OP_DELETE: begin
        if (in_message_key_bytes != upd_key_bytes_r) begin
          acc_reject = 1'b1;
          acc_status = ST_LEN_MISMATCH;
        end
      end
      default: begin
        acc_reject = 1'b1;
      end
    endcase
  end

  // Compare stage: the read data is registered along with its entry index, cmp_idx_r.
  assign rd_key    = rd_data_r[MEM_W-1:STATE_W];
  assign rd_state  = rd_data_r[STATE_W-1:0];
  assign cmp_match = cmp_en_r && valid_r[cmp_idx_r] && (rd_key == key_r);
  assign cmp_free  = cmp_en_r && !valid_r[cmp_idx_r];

  // Merge of the new value into the matched state.
  assign merged    = (match_state_r & ~mask_r) | (nstate_r & mask_r);
  assign ins_state = nstate_r & mask_r;

  // Memory write-back in the decide cycle.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = match_idx_r;
    mem_wdata = {key_r, merged};
    if (state_r == S_DECIDE && op_r == OP_SET) begin
      if (found_r) begin
        mem_we = (merged != '0) && (merged != match_state_r);
      end else if (ins_state != '0 && free_found_r) begin
        mem_we    = 1'b1;
        mem_waddr = free_idx_r;
        mem_wdata = {key_r, ins_state};
      end
    end
  end

  // Key/state memory with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[scan_idx_r];
  end

  // Sequencer, valid bits and registered results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      upd_key_bytes_r  <= '0;
      valid_r          <= '0;
      cmp_en_r         <= 1'b0;
      found_r          <= 1'b0;
      free_found_r     <= 1'b0;
      scan_idx_r       <= '0;
      out_valid        <= 1'b0;
      out_result_state <= '0;
      out_hit          <= 1'b0;
      out_notify       <= 1'b0;
      out_notify_table <= '0;
      out_status       <= ST_OK;
    end else begin
      if (cfg_wr_en) begin
        upd_key_bytes_r <= cfg_wr_data;
      end

      // Results default to zero outside their strobe cycle.
      out_valid        <= 1'b0;
      out_result_state <= '0;
      out_hit          <= 1'b0;
      out_notify       <= 1'b0;
      out_notify_table <= '0;
      out_status       <= ST_OK;

      cmp_en_r  <= 1'b0;
      cmp_idx_r <= scan_idx_r;

      // Track the first matching entry and the lowest free slot.
      if (cmp_match && !found_r) begin
        found_r       <= 1'b1;
        match_idx_r   <= cmp_idx_r;
        match_state_r <= rd_state;
      end
      if (cmp_free && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cmp_idx_r;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r         <= in_operation;
            key_r        <= in_flow_key[KEY_W-1:0];
            nstate_r     <= in_new_state;
            mask_r       <= in_state_mask;
            tab_r        <= in_table_number;
            found_r      <= 1'b0;
            free_found_r <= 1'b0;
            scan_idx_r   <= '0;
            if (acc_reject) begin
              out_valid  <= 1'b1;
              out_status <= acc_status;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cmp_en_r <= 1'b1;
          if (scan_idx_r == LAST_IDX) begin
            state_r <= S_DRAIN;
          end else begin
            scan_idx_r <= scan_idx_r + 1'b1;
          end
        end
        S_DRAIN: begin
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          state_r    <= S_IDLE;
          out_valid  <= 1'b1;
          scan_idx_r <= '0;
          unique case (op_r)
            OP_LOOKUP: begin
              if (found_r) begin
                out_hit          <= 1'b1;
                out_result_state <= match_state_r;
              end
            end
            OP_SET: begin
              if (found_r) begin
                out_hit <= 1'b1;
                if (merged == '0) begin
                  valid_r[match_idx_r] <= 1'b0;
                  out_notify           <= 1'b1;
                  out_notify_table     <= tab_r;
                end else begin
                  out_result_state <= merged;
                  if (merged != match_state_r) begin
                    out_notify       <= 1'b1;
                    out_notify_table <= tab_r;
                  end
                end
              end else if (ins_state != '0) begin
                if (free_found_r) begin
                  valid_r[free_idx_r] <= 1'b1;
                  out_notify          <= 1'b1;
                  out_notify_table    <= tab_r;
                  out_result_state    <= ins_state;
                end else begin
                  out_status <= ST_FULL;
                end
              end
            end
            OP_DELETE: begin
              if (found_r) begin
                valid_r[match_idx_r] <= 1'b0;
                out_hit              <= 1'b1;
                out_notify           <= 1'b1;
                out_notify_table     <= tab_r;
              end
            end
            default: begin
              out_valid <= 1'b1;
            end
          endcase
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // A notification is only sent with a good status.
  a_notify_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_notify |-> (out_valid && out_status == ST_OK))
    else $error("notification with bad status or without strobe");

  // An error status never carries a state value or a hit.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_status != ST_OK) |-> (out_result_state == '0 && !out_hit))
    else $error("error status with state or hit");

  // The decide cycle always produces a result strobe.
  a_decide_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) |=> (out_valid && !busy))
    else $error("decide cycle without result");

  // A checked command that passes goes busy for the scan.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !acc_reject) |=> (busy && !out_valid))
    else $error("accepted command did not start a scan");

endmodule : keyed_flow_state_table_top
`default_nettype wire

[tb/sv/kfst_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow state table checker
// Watches the command, result and configuration ports of the flow state table.
// It keeps its own copy of the table and the update key length and predicts
// the result of every accepted command. It then compares each result strobe
// with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module kfst_checker (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_wr_en,
  input  wire  [kfst_pkg::LEN_W-1:0]       cfg_wr_data,
  input  wire                              start,
  input  wire                              busy,
  input  wire  [kfst_pkg::OP_W-1:0]        in_operation,
  input  wire  [kfst_pkg::FKEY_W-1:0]      in_flow_key,
  input  wire                              in_key_complete,
  input  wire                              in_from_packet,
  input  wire  [kfst_pkg::LEN_W-1:0]       in_message_key_bytes,
  input  wire  [kfst_pkg::STATE_W-1:0]     in_new_state,
  input  wire  [kfst_pkg::STATE_W-1:0]     in_state_mask,
  input  wire  [kfst_pkg::TAB_W-1:0]       in_table_number,
  input  wire                              out_valid,
  input  wire  [kfst_pkg::STATE_W-1:0]     out_result_state,
  input  wire                              out_hit,
  input  wire                              out_notify,
  input  wire  [kfst_pkg::TAB_W-1:0]       out_notify_table,
  input  wire  [kfst_pkg::STAT_W-1:0]      out_status,
  output int                               outstanding,
  output int                               failures
);
  import kfst_pkg::*;

  // Only the low KEY_BYTES bytes of a key take part in matching.
  localparam logic [FKEY_W-1:0] MATCH_MASK = {FKEY_W{1'b1}} >> (FKEY_W - KEY_W);

  typedef struct packed {
    logic [STATE_W-1:0] state;
    logic               hit;
    logic               notify;
    logic [TAB_W-1:0]   notify_tab;
    logic [STAT_W-1:0]  status;
  } flow_result_t;

  // Shadow copy of the table and of the update key length register.
  logic               valid_tbl [TABLE_ENTRIES];
  logic [FKEY_W-1:0]  key_tbl   [TABLE_ENTRIES];
  logic [STATE_W-1:0] state_tbl [TABLE_ENTRIES];
  logic [LEN_W-1:0]   update_len;

  flow_result_t pending_results[$];
  int           error_count = 0;

  // Lowest valid slot holding the key, or -1.
  function automatic int find_entry(input logic [FKEY_W-1:0] key);
    int found;
    found = -1;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (valid_tbl[i] && key_tbl[i] == key) found = i;
    end
    return found;
  endfunction

  // Applies one command to the shadow table and returns the result it gives.
  function automatic flow_result_t apply_command(
    input logic [OP_W-1:0]    op,
    input logic [FKEY_W-1:0]  key,
    input logic               complete,
    input logic               from_pkt,
    input logic [LEN_W-1:0]   msg_len,
    input logic [STATE_W-1:0] nstate,
    input logic [STATE_W-1:0] mask,
    input logic [TAB_W-1:0]   tab
  );
    flow_result_t       r;
    int                 idx;
    logic [STATE_W-1:0] merged;
    r = '0;
    case (op)
      OP_LOOKUP: begin
        if (!complete) begin
          r.status = ST_KEY_MISSING;
        end else begin
          idx = find_entry(key);
          if (idx >= 0) begin
            r.hit   = 1'b1;
            r.state = state_tbl[idx];
          end
        end
      end
      OP_SET: begin
        if (from_pkt && !complete) begin
          r.status = ST_KEY_MISSING;
        end else if (!from_pkt && msg_len != update_len) begin
          r.status = ST_LEN_MISMATCH;
        end else begin
          idx = find_entry(key);
          if (idx >= 0) begin
            merged = (state_tbl[idx] & ~mask) | (nstate & mask);
            r.hit  = 1'b1;
            if (merged == '0) begin
              // Merging down to the default state removes the entry.
              valid_tbl[idx] = 1'b0;
              r.notify       = 1'b1;
            end else begin
              if (merged != state_tbl[idx]) begin
                state_tbl[idx] = merged;
                r.notify       = 1'b1;
              end
              r.state = merged;
            end
          end else if ((nstate & mask) != '0) begin
            // Insert into the lowest free slot, if there is one.
            idx = -1;
            for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
              if (!valid_tbl[i]) idx = i;
            end
            if (idx < 0) begin
              r.status = ST_FULL;
            end else begin
              valid_tbl[idx] = 1'b1;
              key_tbl[idx]   = key;
              state_tbl[idx] = nstate & mask;
              r.notify       = 1'b1;
              r.state        = nstate & mask;
            end
          end
        end
      end
      OP_DELETE: begin
        if (msg_len != update_len) begin
          r.status = ST_LEN_MISMATCH;
        end else begin
          idx = find_entry(key);
          if (idx >= 0) begin
            valid_tbl[idx] = 1'b0;
            r.hit          = 1'b1;
            r.notify       = 1'b1;
          end
        end
      end
      default: begin
        // The unused operation leaves everything at zero.
      end
    endcase
    if (r.notify) r.notify_tab = tab;
    return r;
  endfunction

  // Counts a failure; only the first few are printed in full.
  task automatic note_failure(input string what, input flow_result_t exp_r,
                              input flow_result_t got_r);
    error_count++;
    if (error_count <= 10) begin
      $display("[%0t] %s: expected state %h hit %b notify %b table %h status %0d,",
               $realtime, what, exp_r.state, exp_r.hit, exp_r.notify, exp_r.notify_tab,
               exp_r.status);
      $display("[%0t]   got state %h hit %b notify %b table %h status %0d",
               $realtime, got_r.state, got_r.hit, got_r.notify, got_r.notify_tab,
               got_r.status);
    end
  endtask

  // Check result transfers, then predict new command transfers.
  always @(posedge clk) begin
    flow_result_t exp_r;
    flow_result_t got_r;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        valid_tbl[i] = 1'b0;
        key_tbl[i]   = '0;
        state_tbl[i] = '0;
      end
      update_len = '0;
      pending_results.delete();
    end else begin
      if (out_valid) begin
        got_r = '{state: out_result_state, hit: out_hit, notify: out_notify,
                  notify_tab: out_notify_table, status: out_status};
        if (pending_results.size() == 0) begin
          note_failure("result with no command waiting", '0, got_r);
        end else begin
          exp_r = pending_results.pop_front();
          if (exp_r != got_r) note_failure("result mismatch", exp_r, got_r);
        end
      end
      if (start && !busy) begin
        pending_results.push_back(apply_command(in_operation, in_flow_key & MATCH_MASK,
                                                in_key_complete, in_from_packet,
                                                in_message_key_bytes, in_new_state,
                                                in_state_mask, in_table_number));
      end
      if (cfg_wr_en) update_len = cfg_wr_data;
    end
    outstanding <= pending_results.size();
    failures    <= error_count;
  end

endmodule : kfst_checker

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow state table testbench
// Drives directed and random lookup, set and delete commands into the flow
// state table under several update key lengths and sender idle rates, fills
// the table to overflow, and lets the checker judge every result.
// ----------------------------------------------------------------------------
module testbench;
  import kfst_pkg::*;

  // Operation code that the block rejects with status OK.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int              POOL_SIZE = 80;
  localparam int              PHASES    = 6;
  localparam int              PHASE_LEN = 220;

  logic                 clk                  = 1'b0;
  logic                 rst_n                = 1'b0;
  logic                 cfg_wr_en            = 1'b0;
  logic [LEN_W-1:0]     cfg_wr_data          = '0;
  logic                 start                = 1'b0;
  logic [OP_W-1:0]      in_operation         = '0;
  logic [FKEY_W-1:0]    in_flow_key          = '0;
  logic                 in_key_complete      = 1'b0;
  logic                 in_from_packet       = 1'b0;
  logic [LEN_W-1:0]     in_message_key_bytes = '0;
  logic [STATE_W-1:0]   in_new_state         = '0;
  logic [STATE_W-1:0]   in_state_mask        = '0;
  logic [TAB_W-1:0]     in_table_number      = '0;
  wire                  busy;
  wire                  out_valid;
  wire  [STATE_W-1:0]   out_result_state;
  wire                  out_hit;
  wire                  out_notify;
  wire  [TAB_W-1:0]     out_notify_table;
  wire  [STAT_W-1:0]    out_status;
  int                   outstanding;
  int                   failures;

  // Keys are mostly drawn from a pool a little larger than the table.
  logic [FKEY_W-1:0]    key_pool [POOL_SIZE];
  logic [LEN_W-1:0]     cur_len = '0;

  int unsigned phase_len_cfg [PHASES] = '{8, 0, 3, 8, 1, 5};
  int unsigned phase_idle    [PHASES] = '{0, 47, 17, 0, 47, 17};
  bit          phase_fill    [PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  keyed_flow_state_table_top u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .start                (start),
    .busy                 (busy),
    .in_operation         (in_operation),
    .in_flow_key          (in_flow_key),
    .in_key_complete      (in_key_complete),
    .in_from_packet       (in_from_packet),
    .in_message_key_bytes (in_message_key_bytes),
    .in_new_state         (in_new_state),
    .in_state_mask        (in_state_mask),
    .in_table_number      (in_table_number),
    .out_valid            (out_valid),
    .out_result_state     (out_result_state),
    .out_hit              (out_hit),
    .out_notify           (out_notify),
    .out_notify_table     (out_notify_table),
    .out_status           (out_status)
  );

  kfst_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .start                (start),
    .busy                 (busy),
    .in_operation         (in_operation),
    .in_flow_key          (in_flow_key),
    .in_key_complete      (in_key_complete),
    .in_from_packet       (in_from_packet),
    .in_message_key_bytes (in_message_key_bytes),
    .in_new_state         (in_new_state),
    .in_state_mask        (in_state_mask),
    .in_table_number      (in_table_number),
    .out_valid            (out_valid),
    .out_result_state     (out_result_state),
    .out_hit              (out_hit),
    .out_notify           (out_notify),
    .out_notify_table     (out_notify_table),
    .out_status           (out_status),
    .outstanding          (outstanding),
    .failures             (failures)
  );

  // Presents one command and holds it until the block takes the transfer.
  task automatic issue(input logic [OP_W-1:0] op, input logic [FKEY_W-1:0] key,
                       input logic complete, input logic from_pkt,
                       input logic [LEN_W-1:0] msg_len, input logic [STATE_W-1:0] nstate,
                       input logic [STATE_W-1:0] mask, input logic [TAB_W-1:0] tab);
    start                <= 1'b1;
    in_operation         <= op;
    in_flow_key          <= key;
    in_key_complete      <= complete;
    in_from_packet       <= from_pkt;
    in_message_key_bytes <= msg_len;
    in_new_state         <= nstate;
    in_state_mask        <= mask;
    in_table_number      <= tab;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Holds off the sender until every predicted result has been seen.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
  endtask

  task automatic write_len(input logic [LEN_W-1:0] len);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    cur_len     = len;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Random commands, mostly well formed, with an optional bias toward sets.
  task automatic random_phase(input int count, input int unsigned idle_pct,
                              input bit fill_bias);
    int unsigned        pick;
    logic [OP_W-1:0]    op;
    logic [FKEY_W-1:0]  key;
    logic [LEN_W-1:0]   msg_len;
    logic [STATE_W-1:0] nstate;
    logic [STATE_W-1:0] mask;
    for (int n = 0; n < count; n++) begin
      // Sender idling, with an occasional long gap and a rare full drain.
      while ($urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        if ($urandom_range(0, 19) == 0) repeat ($urandom_range(1, 80)) @(posedge clk);
        else @(posedge clk);
      end
      if ($urandom_range(0, 99) == 0) settle();

      pick = $urandom_range(0, 99);
      if (fill_bias) begin
        op = (pick < 15) ? OP_LOOKUP : (pick < 85) ? OP_SET :
             (pick < 97) ? OP_DELETE : OP_UNUSED;
      end else begin
        op = (pick < 30) ? OP_LOOKUP : (pick < 70) ? OP_SET :
             (pick < 95) ? OP_DELETE : OP_UNUSED;
      end
      if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else key = {$urandom, $urandom};
      msg_len = ($urandom_range(0, 9) < 8) ? cur_len : LEN_W'($urandom_range(0, 15));
      nstate  = $urandom;
      mask    = $urandom;
      case ($urandom_range(0, 7))
        0: begin
          nstate = '0;
          mask   = '1;
        end
        1: mask = '1;
        2: mask = '0;
        3: mask = STATE_W'(1) << $urandom_range(0, STATE_W - 1);
        default: begin
        end
      endcase
      issue(op, key, $urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)), msg_len,
            nstate, mask, 8'($urandom));
    end
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed commands with the update key length at its reset value of zero.
    issue(OP_LOOKUP, '0, 1'b1, 1'b0, 4'd0, '0, '0, 8'h00);
    issue(OP_LOOKUP, '1, 1'b0, 1'b1, 4'd15, '1, '1, 8'hff);
    issue(OP_SET, '1, 1'b0, 1'b1, 4'd0, '1, '1, 8'hff);
    issue(OP_SET, '1, 1'b1, 1'b0, 4'd5, '1, '1, 8'hff);
    issue(OP_SET, '1, 1'b1, 1'b0, 4'd0, '1, '1, 8'hff);
    issue(OP_LOOKUP, '1, 1'b1, 1'b0, 4'd0, '0, '0, 8'h00);
    issue(OP_SET, '1, 1'b0, 1'b0, 4'd0, '1, '1, 8'h5a);
    issue(OP_SET, '1, 1'b1, 1'b1, 4'd9, '0, 32'h0000_ffff, 8'ha5);
    issue(OP_SET, '0, 1'b1, 1'b1, 4'd0, 32'h0000_aaaa, 32'h0000_5555, 8'h3c);
    issue(OP_SET, '1, 1'b1, 1'b1, 4'd0, '0, '1, 8'hff);
    issue(OP_LOOKUP, '1, 1'b1, 1'b0, 4'd0, '0, '0, 8'h00);
    issue(OP_SET, {32{2'b01}}, 1'b1, 1'b1, 4'd8, 32'h8000_0001, 32'h8000_0001, 8'h81);
    issue(OP_DELETE, {32{2'b01}}, 1'b1, 1'b0, 4'd15, '0, '0, 8'h42);
    issue(OP_DELETE, {32{2'b01}}, 1'b0, 1'b1, 4'd0, '0, '0, 8'h7e);
    issue(OP_DELETE, {32{2'b01}}, 1'b1, 1'b0, 4'd0, '0, '0, 8'h7e);
    issue(OP_UNUSED, '1, 1'b1, 1'b1, 4'd15, '1, '1, 8'hff);
    issue(OP_UNUSED, '0, 1'b0, 1'b0, 4'd0, '0, '0, 8'h00);

    // Fill every slot, then try one more insert into the full table.
    for (int i = 0; i <= TABLE_ENTRIES; i++) begin
      issue(OP_SET, key_pool[i], 1'b1, 1'b1, 4'($urandom), $urandom | 32'h1, '1,
            8'($urandom));
    end

    // Random phases, each under its own key length and idle rate.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_len(LEN_W'(phase_len_cfg[p]));
      random_phase(PHASE_LEN, phase_idle[p], phase_fill[p]);
    end

    settle();
    repeat (80) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule : testbench

[sim.f]
src/kfst_pkg.sv
src/keyed_flow_state_table_top.sv
tb/sv/kfst_checker.sv
tb/sv/testbench.sv
